FILE: rtl/core/pfa_pkg.sv
package pfa_pkg;

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd1;
	localparam logic [2:0] FN_NEG = 3'd2;
	localparam logic [2:0] FN_MUL = 3'd3;
	localparam logic [2:0] FN_INV = 3'd4;
	localparam logic [2:0] FN_DIV = 3'd5;

	localparam logic [63:0] MOD_RESET = 64'hFFFF_FFFF_0000_0001;

	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
	} pfa_req_t;

	typedef struct packed {
		logic [63:0] field_result;
		logic        status;
	} pfa_rsp_t;

endpackage

FILE: rtl/core/prime_field_alu.sv
// Add/sub/neg first reduce both operands mod p (two operand reductions, one bit a cycle).
// Multiply then runs a loop in the shared modular adder (double, then add).
// Inverse and divide run extended Euclid: each round is one division
// plus one multiply, so the total depends on the number of gcd rounds.
// One word at a time; busy stays high until the result strobe, results cannot be stalled.
// Reset (arst_n low, asynchronous) idles the sequencer and loads the default modulus.
module prime_field_alu #(
	parameter int DATA_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pfa_pkg::pfa_req_t req,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [63:0]       cfg_data,
	output logic              done,
	output pfa_pkg::pfa_rsp_t rsp
);
	import pfa_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(W);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_REDA   = 4'd1;
	localparam logic [3:0] S_REDB   = 4'd2;
	localparam logic [3:0] S_DISP   = 4'd3;
	localparam logic [3:0] S_INVCHK = 4'd4;
	localparam logic [3:0] S_INVDIV = 4'd5;
	localparam logic [3:0] S_MUL    = 4'd6;
	localparam logic [3:0] S_INVUPD = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	function automatic logic [W-1:0] madd(input logic [W-1:0] x, input logic [W-1:0] y,
			input logic [W-1:0] p);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, p})
			s = s - {1'b0, p};
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] msub(input logic [W-1:0] x, input logic [W-1:0] y,
			input logic [W-1:0] p);
		return (x >= y) ? (x - y) : (x - y + p);
	endfunction

	logic [3:0]   state_q;
	logic [W-1:0] p_q;
	logic [2:0]   func_q;
	logic [W-1:0] a_q, b_q;
	logic [W-1:0] t_q, nt_q, r_q, nr_q, rem_q;
	logic [W-1:0] acc_q, mx_q, my_q;
	logic [CW-1:0] cnt_q;
	logic         phase_q;
	logic         inv_mode_q;
	logic [W-1:0] res_q;
	logic         st_q;
	logic         go_q;
	logic [W-1:0] dend_q, dvs_q;
	logic         div_done;
	logic [W-1:0] div_quo, div_rem;
	logic [W-1:0] madd_y;
	logic [W-1:0] madd_out;

	pfa_divider #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go_q),
		.dividend  (dend_q),
		.divisor   (dvs_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// shared modular adder for the multiply loop
	assign madd_y   = phase_q ? mx_q : acc_q;
	assign madd_out = madd(acc_q, madd_y, p_q);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q     <= MOD_RESET[W-1:0];
			go_q    <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				p_q <= cfg_data[W-1:0];
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q <= req.func;
						b_q    <= req.operand_b[W-1:0];
						if (p_q < W'(2)) begin
							res_q   <= '0;
							st_q    <= (req.func == FN_INV) || (req.func == FN_DIV);
							state_q <= S_DONE;
						end else begin
							dend_q  <= req.operand_a[W-1:0];
							dvs_q   <= p_q;
							go_q    <= 1'b1;
							state_q <= S_REDA;
						end
					end
				end
				S_REDA: begin
					if (div_done) begin
						a_q     <= div_rem;
						dend_q  <= b_q;
						go_q    <= 1'b1;
						state_q <= S_REDB;
					end
				end
				S_REDB: begin
					if (div_done) begin
						b_q     <= div_rem;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					res_q   <= '0;
					st_q    <= 1'b0;
					state_q <= S_DONE;
					t_q     <= '0;
					nt_q    <= W'(1);
					r_q     <= p_q;
					unique case (func_q)
						FN_ADD: res_q <= madd(a_q, b_q, p_q);
						FN_SUB: res_q <= msub(a_q, b_q, p_q);
						FN_NEG: res_q <= msub('0, a_q, p_q);
						FN_MUL: begin
							mx_q       <= a_q;
							my_q       <= b_q;
							acc_q      <= '0;
							cnt_q      <= CW'(W - 1);
							phase_q    <= 1'b0;
							inv_mode_q <= 1'b0;
							state_q    <= S_MUL;
						end
						FN_INV: begin
							if (a_q == '0)
								st_q <= 1'b1;
							else begin
								nr_q    <= a_q;
								state_q <= S_INVCHK;
							end
						end
						FN_DIV: begin
							if (b_q == '0)
								st_q <= 1'b1;
							else begin
								nr_q    <= b_q;
								state_q <= S_INVCHK;
							end
						end
						default: ;
					endcase
				end
				S_INVCHK: begin
					if (nr_q == '0) begin
						if (func_q == FN_DIV) begin
							mx_q       <= a_q;
							my_q       <= t_q;
							acc_q      <= '0;
							cnt_q      <= CW'(W - 1);
							phase_q    <= 1'b0;
							inv_mode_q <= 1'b0;
							state_q    <= S_MUL;
						end else begin
							res_q   <= t_q;
							state_q <= S_DONE;
						end
					end else begin
						dend_q  <= r_q;
						dvs_q   <= nr_q;
						go_q    <= 1'b1;
						state_q <= S_INVDIV;
					end
				end
				S_INVDIV: begin
					if (div_done) begin
						// quotient never exceeds p, one subtract brings it into range
						mx_q       <= (div_quo >= p_q) ? (div_quo - p_q) : div_quo;
						my_q       <= nt_q;
						rem_q      <= div_rem;
						acc_q      <= '0;
						cnt_q      <= CW'(W - 1);
						phase_q    <= 1'b0;
						inv_mode_q <= 1'b1;
						state_q    <= S_MUL;
					end
				end
				S_MUL: begin
					if (!phase_q) begin
						acc_q   <= madd_out;
						phase_q <= 1'b1;
					end else begin
						if (my_q[W-1])
							acc_q <= madd_out;
						my_q    <= {my_q[W-2:0], 1'b0};
						phase_q <= 1'b0;
						cnt_q   <= cnt_q - 1'b1;
						if (cnt_q == '0) begin
							if (inv_mode_q)
								state_q <= S_INVUPD;
							else begin
								res_q   <= my_q[W-1] ? madd_out : acc_q;
								state_q <= S_DONE;
							end
						end
					end
				end
				S_INVUPD: begin
					t_q     <= nt_q;
					nt_q    <= msub(t_q, acc_q, p_q);
					r_q     <= nr_q;
					nr_q    <= rem_q;
					state_q <= S_INVCHK;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy              = (state_q != S_IDLE);
	assign done              = (state_q == S_DONE);
	assign rsp.field_result  = 64'(res_q);
	assign rsp.status        = st_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not raise busy");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status) |-> (rsp.field_result == 64'd0))
		else $error("error word with non-zero result");
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (p_q >= W'(2))) |-> (res_q < p_q)) else $error("result not reduced");

endmodule

FILE: rtl/core/pfa_divider.sv
module pfa_divider #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	import pfa_pkg::*;

	localparam int CW = $clog2(W);

	logic         run_q;
	logic         done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] dq_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] dvs_q;
	logic [W:0]   trial;
	logic         ge;
	logic [W:0]   nrem;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, dq_q[W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign nrem  = ge ? (trial - {1'b0, dvs_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dq_q  <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= nrem[W-1:0];
			dq_q  <= {dq_q[W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import pfa_pkg::*;

	localparam logic [2:0] FN_RSV6 = 3'd6;
	localparam logic [2:0] FN_RSV7 = 3'd7;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] P0 = MOD_RESET;

	typedef struct {
		logic [2:0]  func;
		logic [63:0] a;
		logic [63:0] b;
		bit          typed;
		logic [63:0] res;
		logic        st;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	pfa_req_t    req;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] cfg_data;
	logic        done;
	pfa_rsp_t    rsp;

	pfa_rsp_t    pending_q[$];
	logic [63:0] field_p;
	int          n_err;
	int          n_words;
	int          n_results;
	int          n_moduli;

	prime_field_alu DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.rsp(rsp)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [63:0] fadd(logic [63:0] x, logic [63:0] y, logic [63:0] p);
		logic [64:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, p})
			s = s - {1'b0, p};
		return s[63:0];
	endfunction

	function automatic logic [63:0] fsub(logic [63:0] x, logic [63:0] y, logic [63:0] p);
		return (x >= y) ? (x - y) : (x - y + p);
	endfunction

	function automatic logic [63:0] fmul(logic [63:0] x, logic [63:0] y, logic [63:0] p);
		logic [63:0] acc;
		acc = '0;
		for (int i = 63; i >= 0; i--) begin
			acc = fadd(acc, acc, p);
			if (y[i])
				acc = fadd(acc, x, p);
		end
		return acc;
	endfunction

	// extended Euclid, coefficient kept mod p so it never goes negative
	function automatic logic [63:0] finv(logic [63:0] x, logic [63:0] p);
		logic [63:0] t, nt, r, nr, q, tmp, rem;
		t = '0;
		nt = 64'd1;
		r = p;
		nr = x;
		while (nr != 0) begin
			q = r / nr;
			tmp = fsub(t, fmul(q % p, nt, p), p);
			rem = r % nr;
			t = nt;
			nt = tmp;
			r = nr;
			nr = rem;
		end
		return t;
	endfunction

	function automatic pfa_rsp_t field_predict(pfa_req_t w, logic [63:0] p);
		pfa_rsp_t    o;
		logic [63:0] a, b;
		o.field_result = '0;
		o.status = 1'b0;
		if (p < 2) begin
			o.status = (w.func == FN_INV || w.func == FN_DIV);
			return o;
		end
		a = w.operand_a % p;
		b = w.operand_b % p;
		case (w.func)
			FN_ADD: o.field_result = fadd(a, b, p);
			FN_SUB: o.field_result = fsub(a, b, p);
			FN_NEG: o.field_result = (a == 0) ? '0 : p - a;
			FN_MUL: o.field_result = fmul(a, b, p);
			FN_INV: begin
				if (a == 0) o.status = 1'b1;
				else o.field_result = finv(a, p);
			end
			FN_DIV: begin
				if (b == 0) o.status = 1'b1;
				else o.field_result = fmul(a, finv(b, p), p);
			end
			default: ;
		endcase
		return o;
	endfunction

	// one word per call; start is left high, caller lowers it when done
	task automatic issue_word(pfa_req_t w, bit typed, pfa_rsp_t known, bit may_idle);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		pending_q.push_back(typed ? known : field_predict(w, field_p));
		n_words++;
		@(negedge clk);
	endtask

	task automatic write_modulus(logic [63:0] v);
		start <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		field_p = v;
		n_moduli++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] pick_operand(logic [63:0] p);
		logic [63:0] k;
		k = 64'($urandom_range(0, 15));
		case ($urandom_range(0, 7))
			0: return k;
			1: return p - 1 - (k % p);
			2: return p + k;
			3: return ONES - k;
			4: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [2:0] pick_func(logic [63:0] p);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return ($urandom_range(0, 1) != 0) ? FN_RSV6 : FN_RSV7;
		// wide moduli make inverse slow: keep it rarer there
		if (r < ((p > 64'hFFFF_FFFF) ? 12 : 40))
			return ($urandom_range(0, 1) != 0) ? FN_INV : FN_DIV;
		case ($urandom_range(0, 3))
			0: return FN_ADD;
			1: return FN_SUB;
			2: return FN_NEG;
			default: return FN_MUL;
		endcase
	endfunction

	always @(posedge clk) begin
		pfa_rsp_t want;
		if (arst_n && done) begin
			n_results++;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h/%b",
					$time, rsp.field_result, rsp.status);
				n_err++;
			end else begin
				want = pending_q.pop_front();
				if (rsp.field_result !== want.field_result) begin
					$display("%0t: field_result expected %h actual %h",
						$time, want.field_result, rsp.field_result);
					n_err++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %b actual %b",
						$time, want.status, rsp.status);
					n_err++;
				end
			end
		end
	end

	initial begin
		#400ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		static dir_row_t dir_tab[] = '{
			'{FN_ADD, 64'd0, 64'd0, 1, 64'd0, 1'b0},
			'{FN_ADD, P0 - 1, 64'd1, 1, 64'd0, 1'b0},
			'{FN_SUB, 64'd0, 64'd1, 1, P0 - 1, 1'b0},
			'{FN_NEG, 64'd0, ONES, 1, 64'd0, 1'b0},
			'{FN_NEG, 64'd1, 64'd0, 1, P0 - 1, 1'b0},
			'{FN_MUL, P0 - 1, P0 - 1, 1, 64'd1, 1'b0},
			'{FN_INV, 64'd0, 64'd5, 1, 64'd0, 1'b1},
			'{FN_INV, P0, 64'd0, 1, 64'd0, 1'b1},
			'{FN_INV, 64'd1, 64'd0, 1, 64'd1, 1'b0},
			'{FN_INV, P0 - 1, 64'd0, 1, P0 - 1, 1'b0},
			'{FN_DIV, 64'd5, 64'd0, 1, 64'd0, 1'b1},
			'{FN_DIV, 64'd5, P0, 1, 64'd0, 1'b1},
			'{FN_DIV, 64'd7, 64'd1, 1, 64'd7, 1'b0},
			'{FN_RSV6, 64'd5, 64'd5, 1, 64'd0, 1'b0},
			'{FN_RSV7, ONES, ONES, 1, 64'd0, 1'b0},
			'{FN_ADD, ONES, ONES, 0, 64'd0, 1'b0},
			'{FN_SUB, ONES, 64'd0, 0, 64'd0, 1'b0},
			'{FN_NEG, ONES, 64'd0, 0, 64'd0, 1'b0},
			'{FN_MUL, ONES, ONES, 0, 64'd0, 1'b0},
			'{FN_INV, 64'd2, 64'd0, 0, 64'd0, 1'b0},
			'{FN_DIV, ONES, 64'd3, 0, 64'd0, 1'b0}
		};
		// modulus sweep: reset prime, smallest, small primes, a 61-bit prime, widest prime,
		// all-ones and a small composite
		static logic [63:0] mod_list[] = '{P0, 64'd3, 64'd97, 64'd65537,
			64'h1FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5, ONES, 64'd15};
		static int   cnt_list[] = '{240, 200, 200, 200, 160, 150, 100, 150};
		pfa_req_t    w;
		pfa_rsp_t    known;
		int          total, done_words;

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		field_p = MOD_RESET;
		n_err = 0;
		n_words = 0;
		n_results = 0;
		n_moduli = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			w.func = dir_tab[i].func;
			w.operand_a = dir_tab[i].a;
			w.operand_b = dir_tab[i].b;
			known.field_result = dir_tab[i].res;
			known.status = dir_tab[i].st;
			issue_word(w, dir_tab[i].typed, known, 1'b1);
		end

		total = 0;
		foreach (cnt_list[i]) total += cnt_list[i];
		done_words = 0;
		foreach (mod_list[m]) begin
			write_modulus(mod_list[m]);
			for (int n = 0; n < cnt_list[m]; n++) begin
				w.func = pick_func(field_p);
				w.operand_a = pick_operand(field_p);
				w.operand_b = pick_operand(field_p);
				// no gaps over the final stretch
				issue_word(w, 1'b0, known, done_words < total - 150);
				done_words++;
			end
		end
		start <= 1'b0;

		while (pending_q.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);

		$display("Covered %0d words and %0d results over %0d modulus settings",
			n_words, n_results, n_moduli + 1);
		$display("Ops: add, sub, neg, mul, inv, div, unused codes; zero inverse and div");
		if (n_err == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/pfa_pkg.sv
rtl/core/pfa_divider.sv
rtl/core/prime_field_alu.sv
verif/tb_top.sv
